// ----- design/tdpe_pkg.sv -----
// shared types and constants for the timestamp delta prefix encoder
`timescale 1ns / 1ps

package tdpe_pkg;

    localparam int TS_W        = 63;  // timestamp width in bits
    localparam int BYTE_W      = 8;   // output byte width
    localparam int WORD_W      = 64;  // byte shift word width
    localparam int CNT_W       = 4;   // enough to count eight bytes
    localparam int DELTA_BITS  = 35;  // largest encodable delta is below 2^35
    localparam int GROUP_BITS  = 7;   // payload bits per prefix byte

    localparam logic [CNT_W-1:0] BASE_BYTES = CNT_W'(8);
    localparam logic [CNT_W-1:0] ONE_BYTE   = CNT_W'(1);

    // what the encoder hands to the byte serializer
    typedef struct packed {
        logic [WORD_W-1:0] word;  // bytes to send, first byte in the top bits
        logic [CNT_W-1:0]  cnt;   // number of bytes to send
        logic              err;   // delta out of range
    } t_load;

endpackage

// ----- design/tdpe_encode.sv -----
// combinational encoder: base word, prefix-coded delta or range error
`timescale 1ns / 1ps

module tdpe_encode
    import tdpe_pkg::*;
(
    input  logic [TS_W-1:0] i_ts,
    input  logic            i_restart,
    input  logic [TS_W-1:0] i_prev,
    input  logic            i_base_sent,
    output t_load           o_load
);

    logic [TS_W:0]         diff;
    logic                  neg;
    logic                  big;
    logic [DELTA_BITS-1:0] d;

    // delta with one extra bit to catch a negative result
    assign diff = {1'b0, i_ts} - {1'b0, i_prev};
    assign neg  = diff[TS_W];
    assign big  = |diff[TS_W-1:DELTA_BITS];
    assign d    = diff[DELTA_BITS-1:0];

    // pick the byte count and left-align the prefix code
    always_comb begin
        o_load = '0;
        if (i_restart || !i_base_sent) begin
            o_load.word = {1'b0, i_ts};
            o_load.cnt  = BASE_BYTES;
        end else if (neg || big) begin
            o_load.cnt = ONE_BYTE;
            o_load.err = 1'b1;
        end else if (d[DELTA_BITS-1:GROUP_BITS] == '0) begin
            o_load.word = {1'b1, d[6:0], 56'b0};
            o_load.cnt  = CNT_W'(1);
        end else if (d[DELTA_BITS-1:2*GROUP_BITS] == '0) begin
            o_load.word = {2'b01, d[13:0], 48'b0};
            o_load.cnt  = CNT_W'(2);
        end else if (d[DELTA_BITS-1:3*GROUP_BITS] == '0) begin
            o_load.word = {3'b001, d[20:0], 40'b0};
            o_load.cnt  = CNT_W'(3);
        end else if (d[DELTA_BITS-1:4*GROUP_BITS] == '0) begin
            o_load.word = {4'b0001, d[27:0], 32'b0};
            o_load.cnt  = CNT_W'(4);
        end else begin
            o_load.word = {5'b00001, d[34:0], 24'b0};
            o_load.cnt  = CNT_W'(5);
        end
    end

endmodule

// ----- design/tdpe_serializer.sv -----
// byte shift register that sends one encoded byte per transfer
`timescale 1ns / 1ps

module tdpe_serializer
    import tdpe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ld_valid,
    input  t_load             i_ld,
    output logic              o_ld_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last,
    output logic              o_err
);

    logic [WORD_W-1:0] r_word, n_word;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_err, n_err;
    logic              xfer;

    assign o_valid    = (r_cnt != '0);
    assign o_last     = (r_cnt == ONE_BYTE);
    assign o_byte     = r_word[WORD_W-1 -: BYTE_W];
    assign o_err      = r_err;
    assign xfer       = o_valid && i_ready;
    assign o_ld_ready = !o_valid || (o_last && i_ready);

    // load a new word or shift out the byte just sent
    always_comb begin
        n_word = r_word;
        n_cnt  = r_cnt;
        n_err  = r_err;
        if (i_ld_valid && o_ld_ready) begin
            n_word = i_ld.word;
            n_cnt  = i_ld.cnt;
            n_err  = i_ld.err;
        end else if (xfer) begin
            n_word = {r_word[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            n_cnt  = r_cnt - ONE_BYTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_word <= n_word;
        r_err  <= n_err;
    end

endmodule

// ----- design/timestamp_delta_prefix_encoder_core.sv -----
// top level of the timestamp delta prefix encoder
`timescale 1ns / 1ps

// Takes 63-bit microsecond timestamps and sends a byte stream. A base
// timestamp (first after reset, or restart set) goes out as 8 bytes, most
// significant first; later ones go out as their delta in 1 to 5 prefix-coded
// bytes (k-1 zero bits, a one bit, 7k delta bits). A negative delta or one
// of 2^35 or more gives a single byte 0x00 with tuser set and tlast set; the
// stored timestamp still advances. The output sends one byte per cycle from
// a shift register while the output is not stalled; with no stall a new item
// is taken in the same cycle that the previous item's last byte goes out.
module timestamp_delta_prefix_encoder_core
    import tdpe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // [62:0] timestamp_us, [63] zero
    input  logic              s_axis_tuser,   // [0] restart
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic              m_axis_tlast,   // last_byte
    output logic              m_axis_tuser    // [0] range_error
);

    logic            r_in_valid;
    logic [TS_W-1:0] r_ts;
    logic            r_restart;
    logic [TS_W-1:0] r_prev;
    logic            r_base_sent;
    t_load           enc;
    logic            ld_ready;
    logic            ld;

    assign ld            = r_in_valid && ld_ready;
    assign s_axis_tready = !r_in_valid || ld_ready;

    // input register and timestamp history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_base_sent <= 1'b0;
            r_prev      <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (ld) begin
                r_in_valid <= 1'b0;
            end
            if (ld) begin
                r_prev      <= r_ts;
                r_base_sent <= 1'b1;
            end
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_ts      <= s_axis_tdata[TS_W-1:0];
            r_restart <= s_axis_tuser;
        end
    end

    tdpe_encode u_encode (
        .i_ts        (r_ts),
        .i_restart   (r_restart),
        .i_prev      (r_prev),
        .i_base_sent (r_base_sent),
        .o_load      (enc)
    );

    tdpe_serializer u_serializer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ld_valid (r_in_valid),
        .i_ld       (enc),
        .o_ld_ready (ld_ready),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_last     (m_axis_tlast),
        .o_err      (m_axis_tuser)
    );

endmodule

// ----- design/tdpe_checker.sv -----
// port-level checks for the timestamp delta prefix encoder
`timescale 1ns / 1ps

module tdpe_props
    import tdpe_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [BYTE_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast,
    input logic              m_axis_tuser
);

    // a stalled output transfer keeps its byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // a range error is a single zero byte
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("range error transfer malformed");

    // nothing is sent right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // an empty block with no input in this or the last cycle stays idle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && !s_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready)
            |=> !m_axis_tvalid)
        else $error("output appeared without an input");

endmodule

bind timestamp_delta_prefix_encoder_core tdpe_props u_tdpe_checker (.*);
